// File: sv/itcp_pkg.sv
// shared types and constants of the ipv4/tcp frame parser
package itcp_pkg;

    // chunk and payload sizing
    localparam int CHUNK_BYTES = 16;
    localparam int MAX_PAYLOAD = 1460;
    localparam int CB_IDX_W    = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

    // queue between parser and serializer
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // frame header layout
    localparam logic [10:0] POS_LIMIT    = 11'd2047;
    localparam logic [6:0]  ETH_HDR_LEN  = 7'd14;
    localparam logic [10:0] POS_ETYPE_HI = 11'd12;
    localparam logic [10:0] POS_ETYPE_LO = 11'd13;
    localparam logic [10:0] POS_IHL      = 11'd14;
    localparam logic [10:0] POS_PROTO    = 11'd23;
    localparam logic [10:0] POS_SRC_ADDR = 11'd26;
    localparam logic [10:0] POS_DST_ADDR = 11'd30;
    localparam logic [7:0]  ETYPE_HI     = 8'h08;
    localparam logic [7:0]  ETYPE_LO     = 8'h00;
    localparam logic [7:0]  PROTO_TCP    = 8'h06;
    localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;

    // configuration port
    localparam int          APB_ADDR_W      = 3;
    localparam logic [0:0]  REG_PORT_NUMBER = 1'b0;

    // one chunk record handed from parser to serializer
    typedef struct packed {
        logic [31:0]                  source_address;
        logic [31:0]                  dest_address;
        logic [15:0]                  source_port;
        logic [15:0]                  dest_port;
        logic [31:0]                  sequence_number;
        logic [10:0]                  payload_size;
        logic [15:0]                  ingress_port;
        logic [CHUNK_BYTES-1:0][7:0]  chunk_bytes;
    } chunk_rec_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

endpackage

// File: sv/itcp_front.sv
// frame byte parser: header capture, payload packing, chunk record push
module itcp_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              frame_byte,
    input  logic [10:0]             frame_length,
    input  logic                    end_of_frame,
    input  logic [15:0]             port_number,
    input  itcp_pkg::queue_status_t q_stat,
    output logic                    push,
    output itcp_pkg::chunk_rec_t    push_rec
);

    localparam logic [6:0] ETH_HDR_LEN_F = itcp_pkg::ETH_HDR_LEN;

    logic [10:0] byte_count_reg, byte_count_next, byte_count_upd;
    logic [3:0]  ihl_reg, ihl_next, ihl_upd;
    logic [3:0]  doff_reg, doff_next, doff_upd;
    logic        rejected_reg, rejected_next, rejected_upd;
    logic [31:0] src_addr_reg, src_addr_next, src_addr_upd;
    logic [31:0] dst_addr_reg, dst_addr_next, dst_addr_upd;
    logic [31:0] seq_reg, seq_next, seq_upd;
    logic [15:0] src_port_reg, src_port_next, src_port_upd;
    logic [15:0] dst_port_reg, dst_port_next, dst_port_upd;
    logic [10:0] pay_idx_reg, pay_idx_next, pay_idx_upd;
    logic [itcp_pkg::CHUNK_BYTES-1:0][7:0] store_reg, store_next, store_upd;

    logic        accept;
    logic [6:0]  tcp_start;
    logic [7:0]  pay_start;
    logic [10:0] pay_off;
    logic [10:0] rec_len;
    logic        fire_full;
    logic        fire_eof;

    assign accept   = in_valid && !q_stat.full;
    assign in_stall = q_stat.full;

    // per-byte header and payload update
    always_comb
    begin
        byte_count_upd = byte_count_reg;
        ihl_upd        = ihl_reg;
        doff_upd       = doff_reg;
        rejected_upd   = rejected_reg;
        src_addr_upd   = src_addr_reg;
        dst_addr_upd   = dst_addr_reg;
        seq_upd        = seq_reg;
        src_port_upd   = src_port_reg;
        dst_port_upd   = dst_port_reg;
        pay_idx_upd    = pay_idx_reg;
        store_upd      = store_reg;
        fire_full      = 1'b0;
        tcp_start      = ETH_HDR_LEN_F;
        pay_start      = 8'(ETH_HDR_LEN_F);
        pay_off        = 11'd0;

        if (accept && (byte_count_reg < frame_length) && !rejected_reg)
        begin
            // ethernet and ip header checks
            if (byte_count_reg == itcp_pkg::POS_ETYPE_HI && frame_byte != itcp_pkg::ETYPE_HI)
                rejected_upd = 1'b1;
            if (byte_count_reg == itcp_pkg::POS_ETYPE_LO && frame_byte != itcp_pkg::ETYPE_LO)
                rejected_upd = 1'b1;
            if (byte_count_reg == itcp_pkg::POS_IHL)
            begin
                if (frame_byte[3:0] < itcp_pkg::MIN_HDR_WORDS)
                    rejected_upd = 1'b1;
                else
                    ihl_upd = frame_byte[3:0];
            end
            if (byte_count_reg == itcp_pkg::POS_PROTO && frame_byte != itcp_pkg::PROTO_TCP)
                rejected_upd = 1'b1;

            // ip addresses, first byte most significant
            if (byte_count_reg >= itcp_pkg::POS_SRC_ADDR &&
                byte_count_reg < itcp_pkg::POS_SRC_ADDR + 11'd4)
                src_addr_upd = {src_addr_reg[23:0], frame_byte};
            if (byte_count_reg >= itcp_pkg::POS_DST_ADDR &&
                byte_count_reg < itcp_pkg::POS_DST_ADDR + 11'd4)
                dst_addr_upd = {dst_addr_reg[23:0], frame_byte};

            // tcp header fields
            tcp_start = ETH_HDR_LEN_F + {1'b0, ihl_upd, 2'b00};
            if (!rejected_upd && ihl_upd != 4'd0)
            begin
                if (byte_count_reg >= 11'(tcp_start) &&
                    byte_count_reg < 11'(tcp_start) + 11'd2)
                    src_port_upd = {src_port_reg[7:0], frame_byte};
                if (byte_count_reg >= 11'(tcp_start) + 11'd2 &&
                    byte_count_reg < 11'(tcp_start) + 11'd4)
                    dst_port_upd = {dst_port_reg[7:0], frame_byte};
                if (byte_count_reg >= 11'(tcp_start) + 11'd4 &&
                    byte_count_reg < 11'(tcp_start) + 11'd8)
                    seq_upd = {seq_reg[23:0], frame_byte};
                if (byte_count_reg == 11'(tcp_start) + 11'd12)
                begin
                    if (frame_byte[7:4] < itcp_pkg::MIN_HDR_WORDS)
                        rejected_upd = 1'b1;
                    else
                        doff_upd = frame_byte[7:4];
                end

                // payload bytes into the chunk store
                pay_start = {1'b0, tcp_start} + {2'b00, doff_upd, 2'b00};
                if (!rejected_upd && doff_upd != 4'd0 && byte_count_reg >= 11'(pay_start))
                begin
                    pay_off = byte_count_reg - 11'(pay_start);
                    if (pay_off < 11'(itcp_pkg::MAX_PAYLOAD))
                    begin
                        store_upd[itcp_pkg::CB_IDX_W'(pay_off % itcp_pkg::CHUNK_BYTES)] =
                            frame_byte;
                        pay_idx_upd = pay_off + 11'd1;
                        if ((pay_idx_upd % itcp_pkg::CHUNK_BYTES) == 0)
                            fire_full = 1'b1;
                    end
                end
            end
        end

        // frame position, saturating
        if (accept && byte_count_reg < itcp_pkg::POS_LIMIT)
            byte_count_upd = byte_count_reg + 11'd1;
    end

    // end of frame: flush a partial or empty chunk of a complete frame
    logic [6:0] tcp_start_upd;
    logic [7:0] pay_start_upd;

    assign tcp_start_upd = ETH_HDR_LEN_F + {1'b0, ihl_upd, 2'b00};
    assign pay_start_upd = {1'b0, tcp_start_upd} + {2'b00, doff_upd, 2'b00};
    assign rec_len = (byte_count_upd < frame_length) ? byte_count_upd : frame_length;

    always_comb
    begin
        fire_eof = 1'b0;
        if (accept && end_of_frame && !rejected_upd && ihl_upd != 4'd0 && doff_upd != 4'd0 &&
            rec_len >= 11'(pay_start_upd))
        begin
            if (pay_idx_upd == 11'd0 || (pay_idx_upd % itcp_pkg::CHUNK_BYTES) != 0)
                fire_eof = 1'b1;
        end
    end

    // record snapshot after this byte
    assign push = fire_full || fire_eof;

    always_comb
    begin
        push_rec.source_address  = src_addr_upd;
        push_rec.dest_address    = dst_addr_upd;
        push_rec.source_port     = src_port_upd;
        push_rec.dest_port       = dst_port_upd;
        push_rec.sequence_number = seq_upd;
        push_rec.payload_size    = frame_length - 11'(pay_start_upd);
        push_rec.ingress_port    = port_number;
        push_rec.chunk_bytes     = store_upd;
    end

    // next state, cleared at end of frame
    always_comb
    begin
        if (accept && end_of_frame)
        begin
            byte_count_next = 11'd0;
            ihl_next        = 4'd0;
            doff_next       = 4'd0;
            rejected_next   = 1'b0;
            src_addr_next   = 32'd0;
            dst_addr_next   = 32'd0;
            seq_next        = 32'd0;
            src_port_next   = 16'd0;
            dst_port_next   = 16'd0;
            pay_idx_next    = 11'd0;
            store_next      = '0;
        end
        else
        begin
            byte_count_next = byte_count_upd;
            ihl_next        = ihl_upd;
            doff_next       = doff_upd;
            rejected_next   = rejected_upd;
            src_addr_next   = src_addr_upd;
            dst_addr_next   = dst_addr_upd;
            seq_next        = seq_upd;
            src_port_next   = src_port_upd;
            dst_port_next   = dst_port_upd;
            pay_idx_next    = pay_idx_upd;
            store_next      = fire_full ? '0 : store_upd;
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 11'd0;
            ihl_reg        <= 4'd0;
            doff_reg       <= 4'd0;
            rejected_reg   <= 1'b0;
            src_addr_reg   <= 32'd0;
            dst_addr_reg   <= 32'd0;
            seq_reg        <= 32'd0;
            src_port_reg   <= 16'd0;
            dst_port_reg   <= 16'd0;
            pay_idx_reg    <= 11'd0;
            store_reg      <= '0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            ihl_reg        <= ihl_next;
            doff_reg       <= doff_next;
            rejected_reg   <= rejected_next;
            src_addr_reg   <= src_addr_next;
            dst_addr_reg   <= dst_addr_next;
            seq_reg        <= seq_next;
            src_port_reg   <= src_port_next;
            dst_port_reg   <= dst_port_next;
            pay_idx_reg    <= pay_idx_next;
            store_reg      <= store_next;
        end
    end

endmodule

// File: sv/itcp_queue.sv
// short record queue between parser and serializer
module itcp_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  itcp_pkg::chunk_rec_t    push_rec,
    input  logic                    pop,
    output itcp_pkg::chunk_rec_t    head_rec,
    output itcp_pkg::queue_status_t q_stat
);

    itcp_pkg::chunk_rec_t slot_reg [itcp_pkg::QUEUE_DEPTH];

    logic [itcp_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [itcp_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [itcp_pkg::Q_CNT_W-1:0] count_reg, count_next;

    localparam logic [itcp_pkg::Q_PTR_W-1:0] PTR_LAST =
        itcp_pkg::Q_PTR_W'(itcp_pkg::QUEUE_DEPTH - 1);
    localparam logic [itcp_pkg::Q_CNT_W-1:0] CNT_FULL =
        itcp_pkg::Q_CNT_W'(itcp_pkg::QUEUE_DEPTH);

    assign q_stat.full      = (count_reg == CNT_FULL);
    assign q_stat.not_empty = (count_reg != '0);
    assign head_rec         = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // record slots
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

// File: sv/itcp_back.sv
// chunk serializer: one result request per chunk byte
module itcp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  itcp_pkg::queue_status_t q_stat,
    input  itcp_pkg::chunk_rec_t    head_rec,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [31:0]             source_address,
    output logic [31:0]             dest_address,
    output logic [15:0]             source_port,
    output logic [15:0]             dest_port,
    output logic [31:0]             sequence_number,
    output logic [10:0]             payload_size,
    output logic [15:0]             ingress_port,
    output logic [7:0]              chunk_byte,
    output logic [5:0]              byte_position,
    output logic                    last_of_chunk
);

    localparam logic [itcp_pkg::CB_IDX_W-1:0] POS_LAST =
        itcp_pkg::CB_IDX_W'(itcp_pkg::CHUNK_BYTES - 1);

    itcp_pkg::chunk_rec_t          hold_reg, hold_next;
    logic [itcp_pkg::CB_IDX_W-1:0] pos_reg, pos_next;
    logic                          valid_reg, valid_next;
    logic                          out_acc;
    logic                          is_last;

    assign out_acc = valid_reg && !out_stall;
    assign is_last = (pos_reg == POS_LAST);
    assign pop     = q_stat.not_empty && (!valid_reg || (out_acc && is_last));

    // load a record or step to the next byte
    always_comb
    begin
        hold_next  = hold_reg;
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (pop)
        begin
            hold_next  = head_rec;
            pos_next   = '0;
            valid_next = 1'b1;
        end
        else if (out_acc)
        begin
            if (is_last)
                valid_next = 1'b0;
            else
            begin
                hold_next.chunk_bytes = hold_reg.chunk_bytes >> 8;
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    // result fields
    assign out_valid       = valid_reg;
    assign source_address  = hold_reg.source_address;
    assign dest_address    = hold_reg.dest_address;
    assign source_port     = hold_reg.source_port;
    assign dest_port       = hold_reg.dest_port;
    assign sequence_number = hold_reg.sequence_number;
    assign payload_size    = hold_reg.payload_size;
    assign ingress_port    = hold_reg.ingress_port;
    assign chunk_byte      = hold_reg.chunk_bytes[0];
    assign byte_position   = 6'(pos_reg);
    assign last_of_chunk   = is_last;

endmodule

// File: sv/ipv4_tcp_frame_parser.sv
// top level: config register, parser, record queue and chunk serializer
// the first byte of a chunk is registered in a queue slot, then in the serializer hold register
// throughput: one frame byte per cycle; each chunk then drains as 16 result requests,
// one per cycle while out_stall is low, set by the single serializer output
// input stalls while the two-record queue between parser and serializer is full
// reset clears frame state, queue, serializer and port_number at once; no clearing pass
module ipv4_tcp_frame_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      frame_byte,
    input  logic [10:0]                     frame_length,
    input  logic                            end_of_frame,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [31:0]                     source_address,
    output logic [31:0]                     dest_address,
    output logic [15:0]                     source_port,
    output logic [15:0]                     dest_port,
    output logic [31:0]                     sequence_number,
    output logic [10:0]                     payload_size,
    output logic [15:0]                     ingress_port,
    output logic [7:0]                      chunk_byte,
    output logic [5:0]                      byte_position,
    output logic                            last_of_chunk,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [itcp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [15:0]             port_number_reg;
    logic                    push;
    logic                    pop;
    itcp_pkg::chunk_rec_t    push_rec;
    itcp_pkg::chunk_rec_t    head_rec;
    itcp_pkg::queue_status_t q_stat;

    // config register
    assign pready = 1'b1;
    assign prdata = (paddr[itcp_pkg::APB_ADDR_W-1:2] == itcp_pkg::REG_PORT_NUMBER) ?
                    {16'd0, port_number_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            port_number_reg <= 16'd0;
        else if (psel && penable && pwrite &&
                 paddr[itcp_pkg::APB_ADDR_W-1:2] == itcp_pkg::REG_PORT_NUMBER)
            port_number_reg <= pwdata[15:0];
    end

    // parser
    itcp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .frame_byte   (frame_byte),
        .frame_length (frame_length),
        .end_of_frame (end_of_frame),
        .port_number  (port_number_reg),
        .q_stat       (q_stat),
        .push         (push),
        .push_rec     (push_rec)
    );

    // record queue
    itcp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .q_stat   (q_stat)
    );

    // serializer
    itcp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_stat          (q_stat),
        .head_rec        (head_rec),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .source_address  (source_address),
        .dest_address    (dest_address),
        .source_port     (source_port),
        .dest_port       (dest_port),
        .sequence_number (sequence_number),
        .payload_size    (payload_size),
        .ingress_port    (ingress_port),
        .chunk_byte      (chunk_byte),
        .byte_position   (byte_position),
        .last_of_chunk   (last_of_chunk)
    );

endmodule

// File: verif/tb_ipv4_tcp_frame_parser.sv
// self-checking testbench for the ipv4/tcp frame parser with a built-in chunk predictor
module tb_ipv4_tcp_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] ETYPE_IPV4 = {itcp_pkg::ETYPE_HI, itcp_pkg::ETYPE_LO};
    localparam logic [15:0] ETYPE_IPV6 = 16'h86dd;
    localparam logic [itcp_pkg::APB_ADDR_W-1:0] ADDR_PORT_NUMBER =
        itcp_pkg::APB_ADDR_W'(4 * itcp_pkg::REG_PORT_NUMBER);
    localparam logic [itcp_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED =
        itcp_pkg::APB_ADDR_W'(4);
    localparam int SETTLE_CYCLES = 8;
    localparam int RAND_FRAMES   = 2;

    typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES} hdr_fill_e;

    // one frame to build: header codes, sizes, truncation and length tweaks
    typedef struct {
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [3:0]  ihl;
        logic [3:0]  doff;
        int          pay_len;
        int          extra;
        int          cut;
        int          flen_abs;
        int          flen_delta;
        hdr_fill_e   fill;
        int          exp_chunks;
    } frame_desc_t;

    // one result beat as seen on the output port
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_num;
        logic [10:0] pay_size;
        logic [15:0] ingress;
        logic [7:0]  data;
        logic [5:0]  pos;
        logic        last;
    } seg_beat_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [7:0]                      frame_byte;
    logic [10:0]                     frame_length;
    logic                            end_of_frame;
    logic                            out_valid;
    logic                            out_stall;
    logic [31:0]                     source_address;
    logic [31:0]                     dest_address;
    logic [15:0]                     source_port;
    logic [15:0]                     dest_port;
    logic [31:0]                     sequence_number;
    logic [10:0]                     payload_size;
    logic [15:0]                     ingress_port;
    logic [7:0]                      chunk_byte;
    logic [5:0]                      byte_position;
    logic                            last_of_chunk;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [itcp_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    ipv4_tcp_frame_parser dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .frame_byte      (frame_byte),
        .frame_length    (frame_length),
        .end_of_frame    (end_of_frame),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .source_address  (source_address),
        .dest_address    (dest_address),
        .source_port     (source_port),
        .dest_port       (dest_port),
        .sequence_number (sequence_number),
        .payload_size    (payload_size),
        .ingress_port    (ingress_port),
        .chunk_byte      (chunk_byte),
        .byte_position   (byte_position),
        .last_of_chunk   (last_of_chunk),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // predictor state: one frame in flight plus the port register
    logic [15:0]  port_cfg;
    int unsigned  pos_cnt;
    logic [3:0]   ihl_w;
    logic [3:0]   doff_w;
    logic         rejected;
    logic [31:0]  src_a;
    logic [31:0]  dst_a;
    logic [31:0]  seq_n;
    logic [15:0]  sport;
    logic [15:0]  dport;
    int unsigned  pay_idx;
    logic [7:0]   chunk_buf [itcp_pkg::CHUNK_BYTES];

    seg_beat_t    beat_q [$];
    logic [7:0]   tx_bytes [$];
    logic [10:0]  tx_flen [$];
    int           errors;
    int           chunk_recs;
    int           stall_hold;
    bit           out_calm;

    // directed frames; exp_chunks of -1 leaves the count to the predictor
    frame_desc_t dir_tbl [5] = '{
        '{ETYPE_IPV4, itcp_pkg::PROTO_TCP, 4'd6, 4'd5, 17, 0, -1, -1, 0, FILL_ONES, 2},
        '{ETYPE_IPV4, itcp_pkg::PROTO_TCP, 4'd5, 4'd5, 0,  0, -1, -1, 0, FILL_ZERO, 1},
        '{ETYPE_IPV6, itcp_pkg::PROTO_TCP, 4'd5, 4'd5, 8,  0, 14, -1, 0, FILL_RAND, 0},
        '{ETYPE_IPV4, itcp_pkg::PROTO_TCP, 4'd4, 4'd5, 8,  0, 15, -1, 0, FILL_RAND, 0},
        '{ETYPE_IPV4, itcp_pkg::PROTO_TCP, 4'd5, 4'd5, 8,  0, 3,  0,  0, FILL_RAND, 0}
    };

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard limit on the run
    initial
    begin
        #30ms;
        $display("tb_ipv4_tcp_frame_parser: FAIL");
        $finish;
    end

    task automatic report(input string msg);
        errors++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    function automatic int unsigned tcp_base();
        return 14 + 4 * ihl_w;
    endfunction

    function automatic int unsigned pay_base();
        return 14 + 4 * ihl_w + 4 * doff_w;
    endfunction

    task automatic clear_frame();
        pos_cnt  = 0;
        ihl_w    = '0;
        doff_w   = '0;
        rejected = 1'b0;
        src_a    = '0;
        dst_a    = '0;
        seq_n    = '0;
        sport    = '0;
        dport    = '0;
        pay_idx  = 0;
        foreach (chunk_buf[k]) chunk_buf[k] = '0;
    endtask

    // queue one chunk record as CHUNK_BYTES expected beats, then clear the buffer
    task automatic emit_chunk(input logic [10:0] flen);
        seg_beat_t beat;
        beat.src_addr = src_a;
        beat.dst_addr = dst_a;
        beat.src_port = sport;
        beat.dst_port = dport;
        beat.seq_num  = seq_n;
        beat.pay_size = 11'(32'(flen) - pay_base());
        beat.ingress  = port_cfg;
        for (int k = 0; k < itcp_pkg::CHUNK_BYTES; k++)
        begin
            beat.data = chunk_buf[k];
            beat.pos  = 6'(k);
            beat.last = (k == itcp_pkg::CHUNK_BYTES - 1);
            beat_q.push_back(beat);
            chunk_buf[k] = '0;
        end
    endtask

    // header capture and payload buffering for one in-range byte
    task automatic take_byte(input int unsigned p, input logic [7:0] b,
                             input logic [10:0] flen);
        int unsigned t;
        int unsigned ps;
        int unsigned idx;
        if (p == itcp_pkg::POS_ETYPE_HI && b != itcp_pkg::ETYPE_HI) rejected = 1'b1;
        if (p == itcp_pkg::POS_ETYPE_LO && b != itcp_pkg::ETYPE_LO) rejected = 1'b1;
        if (p == itcp_pkg::POS_IHL)
        begin
            if (b[3:0] < itcp_pkg::MIN_HDR_WORDS) rejected = 1'b1;
            else ihl_w = b[3:0];
        end
        if (p == itcp_pkg::POS_PROTO && b != itcp_pkg::PROTO_TCP) rejected = 1'b1;
        if (p >= itcp_pkg::POS_SRC_ADDR && p < itcp_pkg::POS_SRC_ADDR + 4)
            src_a = {src_a[23:0], b};
        if (p >= itcp_pkg::POS_DST_ADDR && p < itcp_pkg::POS_DST_ADDR + 4)
            dst_a = {dst_a[23:0], b};
        if (rejected || ihl_w == 0) return;

        t = tcp_base();
        if (p >= t && p < t + 2) sport = {sport[7:0], b};
        if (p >= t + 2 && p < t + 4) dport = {dport[7:0], b};
        if (p >= t + 4 && p < t + 8) seq_n = {seq_n[23:0], b};
        if (p == t + 12)
        begin
            if (b[7:4] < itcp_pkg::MIN_HDR_WORDS) rejected = 1'b1;
            else doff_w = b[7:4];
        end
        if (rejected || doff_w == 0) return;

        ps = pay_base();
        if (p < ps) return;
        idx = p - ps;
        if (idx >= itcp_pkg::MAX_PAYLOAD) return;
        chunk_buf[idx % itcp_pkg::CHUNK_BYTES] = b;
        pay_idx = idx + 1;
        if (pay_idx % itcp_pkg::CHUNK_BYTES == 0) emit_chunk(flen);
    endtask

    // expected effect of one accepted request
    task automatic predict_byte(input logic [7:0] b, input logic [10:0] flen,
                                input logic eof);
        int unsigned rec;
        if (pos_cnt < flen && !rejected) take_byte(pos_cnt, b, flen);
        if (pos_cnt < itcp_pkg::POS_LIMIT) pos_cnt++;
        if (eof)
        begin
            rec = (pos_cnt < flen) ? pos_cnt : flen;
            if (!rejected && ihl_w != 0 && doff_w != 0 && rec >= pay_base())
            begin
                if (pay_idx == 0 || pay_idx % itcp_pkg::CHUNK_BYTES != 0) emit_chunk(flen);
            end
            clear_frame();
        end
    endtask

    function automatic logic [7:0] field_byte(input hdr_fill_e f);
        case (f)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hff;
            default:   return 8'($urandom);
        endcase
    endfunction

    // lay out ethernet, ipv4 and tcp headers plus payload into the send queue
    task automatic build_frame(input frame_desc_t d);
        int ip_len;
        int tcp_len;
        int flen;
        tx_bytes.delete();
        tx_flen.delete();
        repeat (12) tx_bytes.push_back(8'($urandom));
        tx_bytes.push_back(d.etype[15:8]);
        tx_bytes.push_back(d.etype[7:0]);
        tx_bytes.push_back({($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'h4, d.ihl});
        repeat (8) tx_bytes.push_back(8'($urandom));
        tx_bytes.push_back(d.proto);
        repeat (2) tx_bytes.push_back(8'($urandom));
        repeat (8) tx_bytes.push_back(field_byte(d.fill));
        ip_len = (d.ihl < 5) ? 20 : 4 * int'(d.ihl);
        repeat (ip_len - 20) tx_bytes.push_back(8'($urandom));
        repeat (8) tx_bytes.push_back(field_byte(d.fill));
        repeat (4) tx_bytes.push_back(8'($urandom));
        tx_bytes.push_back({d.doff, 4'($urandom)});
        repeat (7) tx_bytes.push_back(8'($urandom));
        tcp_len = (d.doff < 5) ? 20 : 4 * int'(d.doff);
        repeat (tcp_len - 20) tx_bytes.push_back(8'($urandom));
        repeat (d.pay_len + d.extra) tx_bytes.push_back(8'($urandom));
        if (d.cut >= 1)
        begin
            while (tx_bytes.size() > d.cut) void'(tx_bytes.pop_back());
        end
        flen = (d.flen_abs >= 0) ? d.flen_abs : tx_bytes.size() + d.flen_delta;
        if (flen < 0) flen = 0;
        if (flen > 2047) flen = 2047;
        repeat (tx_bytes.size()) tx_flen.push_back(11'(flen));
    endtask

    // random bytes with arbitrary, sometimes changing, frame length
    task automatic build_noise();
        int n;
        logic [10:0] flen;
        bit wobble;
        tx_bytes.delete();
        tx_flen.delete();
        n = $urandom_range(1, 6);
        flen = ($urandom_range(0, 1) == 0) ? 11'(n) : 11'($urandom);
        wobble = ($urandom_range(0, 1) == 0);
        repeat (n)
        begin
            tx_bytes.push_back(8'($urandom));
            tx_flen.push_back(wobble ? 11'($urandom) : flen);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // present one request and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic [10:0] flen, input logic eof);
        in_valid     <= 1'b1;
        frame_byte   <= b;
        frame_length <= flen;
        end_of_frame <= eof;
        do @(posedge clk); while (in_stall);
        predict_byte(b, flen, eof);
    endtask

    task automatic wait_empty();
        do @(posedge clk); while (beat_q.size() != 0);
    endtask

    // push the send queue through, with gaps, an optional drain pause and a parked end
    task automatic send_frame(input bit quiet, input int pause_at, input bit park);
        int n;
        int gap;
        bit hold;
        n = tx_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            send_byte(tx_bytes[i], tx_flen[i], i == n - 1);
            gap = quiet ? 0 : pick_gap();
            hold = (i == pause_at);
            if (i == n - 1 && park && gap == 0) gap = 1;
            if (gap > 0 || hold)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                if (hold) wait_empty();
            end
        end
    endtask

    task automatic cfg_write(input logic [itcp_pkg::APB_ADDR_W-1:0] addr,
                             input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_PORT_NUMBER) port_cfg = val;
        @(posedge clk);
    endtask

    task automatic cfg_check();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_PORT_NUMBER;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[15:0] !== port_cfg)
            report($sformatf("port_number read %h want %h", prdata[15:0], port_cfg));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // idle the block fully, then change the port register
    task automatic reconfigure(input logic [itcp_pkg::APB_ADDR_W-1:0] addr,
                               input logic [15:0] val);
        wait_empty();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write(addr, val);
        cfg_check();
    endtask

    // receiver stall pattern: mostly open, short holds, a few long ones
    always @(posedge clk)
    begin : stall_gen
        int r;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_hold = 0;
        end
        else if (stall_hold > 0)
            stall_hold--;
        else
        begin
            r = $urandom_range(0, 99);
            if (out_calm || r < 65)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                stall_hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    // compare each accepted result with the oldest expected beat
    always @(posedge clk)
    begin : result_check
        seg_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (beat_q.size() == 0)
                report("result with nothing expected");
            else
            begin
                want = beat_q.pop_front();
                if (source_address !== want.src_addr)
                    report($sformatf("source_address %h want %h", source_address,
                                     want.src_addr));
                if (dest_address !== want.dst_addr)
                    report($sformatf("dest_address %h want %h", dest_address, want.dst_addr));
                if (source_port !== want.src_port)
                    report($sformatf("source_port %h want %h", source_port, want.src_port));
                if (dest_port !== want.dst_port)
                    report($sformatf("dest_port %h want %h", dest_port, want.dst_port));
                if (sequence_number !== want.seq_num)
                    report($sformatf("sequence_number %h want %h", sequence_number,
                                     want.seq_num));
                if (payload_size !== want.pay_size)
                    report($sformatf("payload_size %0d want %0d", payload_size,
                                     want.pay_size));
                if (ingress_port !== want.ingress)
                    report($sformatf("ingress_port %h want %h", ingress_port, want.ingress));
                if (chunk_byte !== want.data)
                    report($sformatf("chunk_byte %h want %h", chunk_byte, want.data));
                if (byte_position !== want.pos)
                    report($sformatf("byte_position %0d want %0d", byte_position, want.pos));
                if (last_of_chunk !== want.last)
                    report($sformatf("last_of_chunk %b want %b", last_of_chunk, want.last));
            end
            if (last_of_chunk === 1'b1) chunk_recs++;
        end
    end

    // main sequence: reset, directed frames, random frames, drain
    initial
    begin
        int base;
        bit park;
        int pause_at;
        in_valid     <= 1'b0;
        frame_byte   <= '0;
        frame_length <= '0;
        end_of_frame <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        rst_n        <= 1'b0;
        errors     = 0;
        chunk_recs = 0;
        out_calm   = 1'b0;
        port_cfg   = '0;
        clear_frame();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_check();
        cfg_write(ADDR_PORT_NUMBER, 16'h0000);
        cfg_check();

        // directed frames, one at a time, each drained before the next
        foreach (dir_tbl[i])
        begin
            if (i == 1) reconfigure(ADDR_PORT_NUMBER, 16'hffff);
            base = chunk_recs;
            build_frame(dir_tbl[i]);
            send_frame(1'b0, -1, 1'b1);
            wait_empty();
            repeat (SETTLE_CYCLES) @(posedge clk);
            if (dir_tbl[i].exp_chunks >= 0 && chunk_recs - base != dir_tbl[i].exp_chunks)
                report($sformatf("directed frame %0d gave %0d chunks want %0d", i,
                                 chunk_recs - base, dir_tbl[i].exp_chunks));
        end

        reconfigure(ADDR_PORT_NUMBER, 16'($urandom));

        // random short bursts with arbitrary frame lengths
        for (int f = 0; f < RAND_FRAMES; f++)
        begin
            if (f == 1)
            begin
                reconfigure(ADDR_UNMAPPED, 16'($urandom));
                cfg_write(ADDR_PORT_NUMBER, 16'h0000);
                cfg_check();
            end
            out_calm = ($urandom_range(0, 4) == 0);
            build_noise();
            park = (f == 0 || f == RAND_FRAMES - 1 || $urandom_range(0, 3) == 0);
            pause_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, tx_bytes.size() - 1))
                                                   : -1;
            send_frame($urandom_range(0, 4) == 0, pause_at, park);
        end

        wait_empty();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_ipv4_tcp_frame_parser: PASS");
        else
            $display("tb_ipv4_tcp_frame_parser: FAIL");
        $finish;
    end

endmodule
